// File: rtl/core/aais_pkg.sv
// Shared types and constants for the area-average image scaler.
// Used by the multiply-accumulate unit, the finish divider and the top level.
`timescale 1ns / 1ps

package aais_pkg;

  localparam int UNIT      = 4096;
  localparam int HALF_UNIT = 2048;
  localparam int CHAN_MAX  = 255;

  localparam int FRAC_W    = 13;
  localparam int STEP_W    = 24;
  localparam int CACC_W    = 29;
  localparam int AACC_W    = 21;
  localparam int PIX_W     = 32;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SRC_WIDTH  = 3'd0;
  localparam cfg_idx_t CFG_SRC_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_DST_WIDTH  = 3'd2;
  localparam cfg_idx_t CFG_DST_HEIGHT = 3'd3;
  localparam cfg_idx_t CFG_X_STEP     = 3'd4;
  localparam cfg_idx_t CFG_Y_STEP     = 3'd5;

  typedef logic [CACC_W-1:0] cacc_t;
  typedef logic [AACC_W-1:0] aacc_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic clear_first;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_REQ,
    ST_V_INIT,
    ST_V_WALK,
    ST_V_TAIL,
    ST_V_LAST,
    ST_V_RD,
    ST_V_MAC,
    ST_V_MWAIT,
    ST_V_FWAIT,
    ST_H_INIT,
    ST_H_LOOP,
    ST_H_CHK,
    ST_H_MWAIT,
    ST_H_TAILRD,
    ST_H_MWAIT_EMIT,
    ST_H_FWAIT,
    ST_OUT
  } state_t;

endpackage

// File: rtl/core/aais_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module aais_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/aais_mac.sv
// Alpha-weighted multiply-accumulate unit: one shared 21x8 multiplier, five steps per add.
// Depends on aais_pkg.
`timescale 1ns / 1ps

module aais_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  aais_pkg::mac_cmd_t                 cmd,
  input  logic [aais_pkg::PIX_W-1:0]         px,
  input  logic [aais_pkg::FRAC_W-1:0]        weight,
  output aais_pkg::unit_status_t             status,
  output logic [2:0][aais_pkg::CACC_W-1:0]   acc_c,
  output aais_pkg::aacc_t                    acc_a
);
  import aais_pkg::*;

  logic [PIX_W-1:0]  px_r;
  logic [FRAC_W-1:0] w_r;
  logic [AACC_W-1:0] wa;
  logic [CACC_W-1:0] prod;
  logic [2:0]        step;
  logic              busy;
  logic              done;

  logic [AACC_W-1:0] mul_a;
  logic [7:0]        mul_b;
  logic [CACC_W-1:0] mul_p;

  always_comb begin
    case (step)
      3'd0: begin
        mul_a = AACC_W'(w_r);
        mul_b = px_r[31:24];
      end
      3'd1: begin
        mul_a = prod[AACC_W-1:0];
        mul_b = px_r[7:0];
      end
      3'd2: begin
        mul_a = wa;
        mul_b = px_r[15:8];
      end
      3'd3: begin
        mul_a = wa;
        mul_b = px_r[23:16];
      end
      default: begin
        mul_a = wa;
        mul_b = 8'd0;
      end
    endcase
  end

  assign mul_p = {{(CACC_W-AACC_W){1'b0}}, mul_a} * {{(CACC_W-8){1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      step  <= 3'd0;
      acc_c <= {3{CACC_W'(HALF_UNIT)}};
      acc_a <= AACC_W'(HALF_UNIT);
    end else begin
      done <= 1'b0;
      if (cmd.clear || (cmd.start && cmd.clear_first)) begin
        acc_c <= {3{CACC_W'(HALF_UNIT)}};
        acc_a <= AACC_W'(HALF_UNIT);
      end
      if (cmd.start) begin
        px_r <= px;
        w_r  <= weight;
        step <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        case (step)
          3'd0: begin
            prod <= mul_p;
            step <= 3'd1;
          end
          3'd1: begin
            wa   <= prod[AACC_W-1:0];
            prod <= mul_p;
            step <= 3'd2;
          end
          3'd2: begin
            acc_c[0] <= acc_c[0] + prod;
            prod     <= mul_p;
            step     <= 3'd3;
          end
          3'd3: begin
            acc_c[1] <= acc_c[1] + prod;
            prod     <= mul_p;
            step     <= 3'd4;
          end
          3'd4: begin
            acc_c[2] <= acc_c[2] + prod;
            acc_a    <= acc_a + wa;
            busy     <= 1'b0;
            done     <= 1'b1;
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

// File: rtl/core/aais_finish.sv
// Finish unit: divides each colour sum by the alpha sum, one quotient bit per cycle, saturated.
// Depends on aais_pkg.
`timescale 1ns / 1ps

module aais_finish (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [2:0][aais_pkg::CACC_W-1:0]  c,
  input  aais_pkg::aacc_t                   a,
  output aais_pkg::unit_status_t            status,
  output logic [aais_pkg::PIX_W-1:0]        px
);
  import aais_pkg::*;

  logic [2:0][CACC_W-1:0] ca;
  logic [AACC_W-1:0]      a_r;
  logic [CACC_W-1:0]      rem;
  logic [CACC_W-1:0]      dsh;
  logic [7:0]             q;
  logic [2:0][7:0]        qv;
  logic [1:0]             k;
  logic [2:0]             bcnt;
  logic                   load;
  logic                   busy;
  logic                   done;

  logic [CACC_W-1:0] cur;
  logic              sat;
  logic              qbit;
  logic [CACC_W-1:0] rem_n;
  logic [7:0]        q_n;
  logic [7:0]        qk_fin;
  logic [7:0]        alpha8;
  logic              last_bit;

  always_comb begin
    cur      = ca[k];
    sat      = cur >= {a_r, 8'd0};
    qbit     = rem >= dsh;
    rem_n    = qbit ? rem - dsh : rem;
    q_n      = {q[6:0], qbit};
    last_bit = (bcnt == 3'd0);
    qk_fin   = load ? 8'(CHAN_MAX) : q_n;
    alpha8   = a_r[20] ? 8'(CHAN_MAX) : a_r[19:12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      load <= 1'b0;
      k    <= 2'd0;
      bcnt <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (a == '0) begin
          px   <= '0;
          done <= 1'b1;
        end else begin
          ca   <= c;
          a_r  <= a;
          k    <= 2'd0;
          load <= 1'b1;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (load && !sat) begin
          rem  <= cur;
          dsh  <= CACC_W'({a_r, 7'd0});
          q    <= 8'd0;
          bcnt <= 3'd7;
          load <= 1'b0;
        end else if (load || last_bit) begin
          qv[k] <= qk_fin;
          if (k == 2'd2) begin
            px   <= {alpha8, qk_fin, qv[1], qv[0]};
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            k <= k + 2'd1;
          end
          load <= 1'b1;
        end else begin
          rem  <= rem_n;
          dsh  <= dsh >> 1;
          q    <= q_n;
          bcnt <= bcnt - 3'd1;
        end
      end
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

// File: rtl/core/area_average_image_scaler.sv
// Area-average RGBA image scaler: a load item writes one source pixel into the frame store; a
// request item returns the next output pixel in raster order. The first pixel of each output
// row runs the vertical pass: it walks the row steps, then for every source column makes one
// weighted add per covered source row on the shared multiply-accumulate unit and one division
// in the finish divider. Every other pixel walks the source columns that it passes, with a
// weighted add per covered source column and one division in the finish divider.
// Depends on aais_pkg, aais_ram, aais_mac and aais_finish.
`timescale 1ns / 1ps

module area_average_image_scaler #(
  parameter int MAX_SRC_WIDTH  = 128,
  parameter int MAX_SRC_HEIGHT = 128,
  parameter int MAX_DST_SIZE   = 4095
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  aais_pkg::cfg_idx_t     cfg_index,
  input  logic [23:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic [6:0]             src_col,
  input  logic [6:0]             src_row,
  input  logic [7:0]             in_red,
  input  logic [7:0]             in_green,
  input  logic [7:0]             in_blue,
  input  logic [7:0]             in_alpha,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic [7:0]             out_alpha,
  output logic [11:0]            out_col,
  output logic [11:0]            out_row,
  output logic                   row_end,
  output logic                   image_end
);
  import aais_pkg::*;

  localparam int CIW    = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int CNW    = $clog2(MAX_SRC_WIDTH + 1);
  localparam int RIW    = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
  localparam int RNW    = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int FDEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int DNW    = $clog2(MAX_DST_SIZE + 1);

  logic [7:0]        src_width;
  logic [7:0]        src_height;
  logic [11:0]       dst_width;
  logic [11:0]       dst_height;
  logic [STEP_W-1:0] x_step;
  logic [STEP_W-1:0] y_step;

  state_t state, state_next;

  logic [RNW-1:0]    rows_read;
  logic [STEP_W-1:0] frac_row_left;
  logic              need_row;
  logic [FRAC_W-1:0] fill;
  logic [FRAC_W-1:0] cur_w;
  logic [RIW-1:0]    r0i;
  logic [RIW-1:0]    r1i;
  logic [RIW-1:0]    vr;
  logic [CIW-1:0]    vc;
  logic [STEP_W-1:0] frac_col_left;
  logic [FRAC_W-1:0] frac_col_fill;
  logic [CNW-1:0]    src_col_pos;
  logic              need_col;
  logic [DNW-1:0]    out_col_pos;
  logic [DNW-1:0]    out_row_pos;
  logic [PIX_W-1:0]  px_r;

  logic [CNW-1:0] cols;
  logic [RNW-1:0] rows;
  logic [DNW-1:0] dw;
  logic [DNW-1:0] dh;
  logic [RNW-1:0] rr_cl;
  logic           walk_go;
  logic           row_inc;
  logic           col_in;
  logic           pos_row_end;
  logic           pos_image_end;
  logic           in_take;
  logic           out_free;

  logic              frame_we;
  logic [FAW-1:0]    frame_waddr;
  logic [FAW-1:0]    frame_raddr;
  logic [PIX_W-1:0]  frame_wdata;
  logic [PIX_W-1:0]  frame_rdata;
  logic              wt_we;
  logic [RIW-1:0]    wt_waddr;
  logic [FRAC_W-1:0] wt_rdata;
  logic              rs_we;
  logic [CIW-1:0]    rs_raddr;
  logic [PIX_W-1:0]  rs_rdata;

  mac_cmd_t               mac_cmd;
  logic [PIX_W-1:0]       mac_px;
  logic [FRAC_W-1:0]      mac_w;
  unit_status_t           mac_status;
  logic [2:0][CACC_W-1:0] acc_c;
  aacc_t                  acc_a;
  logic                   fin_start;
  unit_status_t           fin_status;
  logic [PIX_W-1:0]       fin_px;

  always_comb begin
    if (src_width == 8'd0) begin
      cols = CNW'(1);
    end else if (32'(src_width) > MAX_SRC_WIDTH) begin
      cols = CNW'(MAX_SRC_WIDTH);
    end else begin
      cols = CNW'(src_width);
    end
    if (src_height == 8'd0) begin
      rows = RNW'(1);
    end else if (32'(src_height) > MAX_SRC_HEIGHT) begin
      rows = RNW'(MAX_SRC_HEIGHT);
    end else begin
      rows = RNW'(src_height);
    end
    if (dst_width == 12'd0) begin
      dw = DNW'(1);
    end else if (32'(dst_width) > MAX_DST_SIZE) begin
      dw = DNW'(MAX_DST_SIZE);
    end else begin
      dw = DNW'(dst_width);
    end
    if (dst_height == 12'd0) begin
      dh = DNW'(1);
    end else if (32'(dst_height) > MAX_DST_SIZE) begin
      dh = DNW'(MAX_DST_SIZE);
    end else begin
      dh = DNW'(dst_height);
    end
    if (rows_read == '0) begin
      rr_cl = RNW'(1);
    end else if (rows_read > rows) begin
      rr_cl = rows;
    end else begin
      rr_cl = rows_read;
    end
  end

  assign walk_go       = (frac_row_left < STEP_W'(fill)) && (frac_row_left != '0);
  assign row_inc       = need_row && (rows_read < rows);
  assign col_in        = src_col_pos < cols;
  assign pos_row_end   = out_col_pos >= dw - DNW'(1);
  assign pos_image_end = pos_row_end && (out_row_pos >= dh - DNW'(1));
  assign in_stall      = (state != ST_IDLE);
  assign in_take       = in_valid && !in_stall;
  assign out_free      = !out_valid || !out_stall;
  assign cfg_ready     = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take && op) begin
          state_next = ST_REQ;
        end
      end
      ST_REQ: begin
        state_next = (out_col_pos == '0) ? ST_V_INIT : ST_H_LOOP;
      end
      ST_V_INIT: begin
        state_next = ST_V_WALK;
      end
      ST_V_WALK: begin
        if (!walk_go) begin
          state_next = ST_V_TAIL;
        end
      end
      ST_V_TAIL: begin
        state_next = ST_V_LAST;
      end
      ST_V_LAST: begin
        state_next = ST_V_RD;
      end
      ST_V_RD: begin
        state_next = ST_V_MAC;
      end
      ST_V_MAC: begin
        state_next = ST_V_MWAIT;
      end
      ST_V_MWAIT: begin
        if (mac_status.done) begin
          state_next = (vr == r1i) ? ST_V_FWAIT : ST_V_RD;
        end
      end
      ST_V_FWAIT: begin
        if (fin_status.done) begin
          state_next = (CNW'(vc) == cols - CNW'(1)) ? ST_H_INIT : ST_V_RD;
        end
      end
      ST_H_INIT: begin
        state_next = ST_H_LOOP;
      end
      ST_H_LOOP: begin
        if (col_in) begin
          state_next = ST_H_CHK;
        end else if (need_col) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_H_TAILRD;
        end
      end
      ST_H_CHK: begin
        if (frac_col_left >= STEP_W'(frac_col_fill)) begin
          state_next = ST_H_MWAIT_EMIT;
        end else if (frac_col_left != '0) begin
          state_next = ST_H_MWAIT;
        end else begin
          state_next = ST_H_LOOP;
        end
      end
      ST_H_MWAIT: begin
        if (mac_status.done) begin
          state_next = ST_H_LOOP;
        end
      end
      ST_H_TAILRD: begin
        state_next = ST_H_MWAIT_EMIT;
      end
      ST_H_MWAIT_EMIT: begin
        if (mac_status.done) begin
          state_next = ST_H_FWAIT;
        end
      end
      ST_H_FWAIT: begin
        if (fin_status.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    frame_we    = 1'b0;
    wt_we       = 1'b0;
    rs_we       = 1'b0;
    mac_cmd     = '0;
    mac_px      = rs_rdata;
    mac_w       = frac_col_fill;
    fin_start   = 1'b0;
    case (state)
      ST_IDLE: begin
        frame_we = in_take && !op && (32'(src_col) < MAX_SRC_WIDTH) &&
                   (32'(src_row) < MAX_SRC_HEIGHT);
      end
      ST_V_WALK: begin
        wt_we = walk_go && row_inc;
      end
      ST_V_TAIL: begin
        wt_we = row_inc;
      end
      ST_V_LAST: begin
        wt_we = 1'b1;
      end
      ST_V_MAC: begin
        mac_cmd.start       = 1'b1;
        mac_cmd.clear_first = (vr == r0i);
        mac_px              = frame_rdata;
        mac_w               = wt_rdata;
      end
      ST_V_MWAIT: begin
        fin_start = mac_status.done && (vr == r1i);
      end
      ST_V_FWAIT: begin
        rs_we = fin_status.done;
      end
      ST_H_INIT: begin
        mac_cmd.clear = 1'b1;
      end
      ST_H_CHK: begin
        if (frac_col_left >= STEP_W'(frac_col_fill)) begin
          mac_cmd.start       = 1'b1;
          mac_cmd.clear_first = need_col;
        end else if (frac_col_left != '0) begin
          mac_cmd.start       = 1'b1;
          mac_cmd.clear_first = need_col;
          mac_w               = frac_col_left[FRAC_W-1:0];
        end
      end
      ST_H_TAILRD: begin
        mac_cmd.start = 1'b1;
      end
      ST_H_MWAIT_EMIT: begin
        fin_start = mac_status.done;
      end
      default: begin
        frame_we = 1'b0;
      end
    endcase
  end

  assign frame_waddr = FAW'(32'(src_row) * MAX_SRC_WIDTH + 32'(src_col));
  assign frame_wdata = {in_alpha, in_blue, in_green, in_red};
  assign frame_raddr = FAW'(32'(vr) * MAX_SRC_WIDTH + 32'(vc));
  assign wt_waddr    = RIW'(rows_read - RNW'(1));
  assign rs_raddr    = col_in ? src_col_pos[CIW-1:0] : CIW'(cols - CNW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      src_width     <= 8'd1;
      src_height    <= 8'd1;
      dst_width     <= 12'd1;
      dst_height    <= 12'd1;
      x_step        <= STEP_W'(UNIT);
      y_step        <= STEP_W'(UNIT);
      rows_read     <= RNW'(1);
      frac_row_left <= STEP_W'(UNIT);
      need_row      <= 1'b0;
      frac_col_left <= '0;
      frac_col_fill <= FRAC_W'(UNIT);
      src_col_pos   <= '0;
      need_col      <= 1'b0;
      out_col_pos   <= '0;
      out_row_pos   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SRC_WIDTH:  src_width  <= cfg_data[7:0];
          CFG_SRC_HEIGHT: src_height <= cfg_data[7:0];
          CFG_DST_WIDTH:  dst_width  <= cfg_data[11:0];
          CFG_DST_HEIGHT: dst_height <= cfg_data[11:0];
          CFG_X_STEP:     x_step     <= cfg_data;
          CFG_Y_STEP:     y_step     <= cfg_data;
          default:        src_width  <= src_width;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_REQ: begin
          if (out_col_pos == '0 && out_row_pos == '0) begin
            rows_read     <= RNW'(1);
            frac_row_left <= y_step;
            need_row      <= 1'b0;
          end
        end
        ST_V_INIT: begin
          rows_read <= rr_cl;
          r0i       <= RIW'(rr_cl - RNW'(1));
          fill      <= FRAC_W'(UNIT);
          cur_w     <= '0;
        end
        ST_V_WALK: begin
          if (walk_go) begin
            if (row_inc) begin
              rows_read <= rows_read + RNW'(1);
              cur_w     <= frac_row_left[FRAC_W-1:0];
            end else begin
              cur_w <= cur_w + frac_row_left[FRAC_W-1:0];
            end
            fill          <= fill - frac_row_left[FRAC_W-1:0];
            frac_row_left <= y_step;
            need_row      <= 1'b1;
          end
        end
        ST_V_TAIL: begin
          if (row_inc) begin
            rows_read <= rows_read + RNW'(1);
            need_row  <= 1'b0;
            cur_w     <= fill;
          end else begin
            cur_w <= cur_w + fill;
          end
        end
        ST_V_LAST: begin
          r1i <= RIW'(rows_read - RNW'(1));
          if (frac_row_left <= STEP_W'(fill)) begin
            frac_row_left <= y_step;
            need_row      <= 1'b1;
          end else begin
            frac_row_left <= frac_row_left - STEP_W'(fill);
          end
          vr <= r0i;
          vc <= '0;
        end
        ST_V_MWAIT: begin
          if (mac_status.done && vr != r1i) begin
            vr <= vr + RIW'(1);
          end
        end
        ST_V_FWAIT: begin
          if (fin_status.done) begin
            vr <= r0i;
            vc <= vc + CIW'(1);
          end
        end
        ST_H_INIT: begin
          src_col_pos   <= '0;
          frac_col_left <= x_step;
          frac_col_fill <= FRAC_W'(UNIT);
          need_col      <= 1'b0;
        end
        ST_H_LOOP: begin
          if (!col_in && need_col) begin
            px_r <= '0;
          end
        end
        ST_H_CHK: begin
          if (frac_col_left >= STEP_W'(frac_col_fill)) begin
            frac_col_left <= frac_col_left - STEP_W'(frac_col_fill);
            frac_col_fill <= FRAC_W'(UNIT);
            need_col      <= 1'b1;
          end else begin
            if (frac_col_left != '0) begin
              need_col      <= 1'b0;
              frac_col_fill <= frac_col_fill - frac_col_left[FRAC_W-1:0];
            end
            src_col_pos   <= src_col_pos + CNW'(1);
            frac_col_left <= x_step;
          end
        end
        ST_H_TAILRD: begin
          need_col <= 1'b1;
        end
        ST_H_FWAIT: begin
          if (fin_status.done) begin
            px_r <= fin_px;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_red   <= px_r[7:0];
            out_green <= px_r[15:8];
            out_blue  <= px_r[23:16];
            out_alpha <= px_r[31:24];
            out_col   <= 12'(out_col_pos);
            out_row   <= 12'(out_row_pos);
            row_end   <= pos_row_end;
            image_end <= pos_image_end;
            if (pos_image_end) begin
              out_col_pos <= '0;
              out_row_pos <= '0;
            end else if (pos_row_end) begin
              out_col_pos <= '0;
              out_row_pos <= out_row_pos + DNW'(1);
            end else begin
              out_col_pos <= out_col_pos + DNW'(1);
            end
          end
        end
        default: begin
          need_row <= need_row;
        end
      endcase
    end
  end

  aais_ram #(.WIDTH(PIX_W), .DEPTH(FDEPTH)) u_frame_store (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  aais_ram #(.WIDTH(FRAC_W), .DEPTH(MAX_SRC_HEIGHT)) u_weight_store (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (cur_w),
    .raddr (vr),
    .rdata (wt_rdata)
  );

  aais_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SRC_WIDTH)) u_row_store (
    .clk   (clk),
    .we    (rs_we),
    .waddr (vc),
    .wdata (fin_px),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  aais_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mac_cmd),
    .px     (mac_px),
    .weight (mac_w),
    .status (mac_status),
    .acc_c  (acc_c),
    .acc_a  (acc_a)
  );

  aais_finish u_finish (
    .clk    (clk),
    .rst    (rst),
    .start  (fin_start),
    .c      (acc_c),
    .a      (acc_a),
    .status (fin_status),
    .px     (fin_px)
  );

endmodule
